// ===== rtl/core/prw_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// prw_pkg
// Shared types and constants of the page reorder window: word layouts,
// register indexes, result kinds and the controller to datapath bundles.
// ----------------------------------------------------------------------------
package prw_pkg;

   // window and page limits
   localparam int MAX_WINDOW     = 16;
   localparam int MAX_PAGE_BYTES = 4096;

   // field widths
   localparam int SLOT_W     = $clog2(MAX_WINDOW);
   localparam int WIN_W      = SLOT_W + 1;
   localparam int PAGE_W     = 13;
   localparam int PAGE_NUM_W = 24;
   localparam int TSIZE_W    = 36;
   localparam int MAP_W      = 16;
   localparam int CSR_IDX_W  = 2;

   // remainder unit sizing
   localparam int DIV_W  = TSIZE_W;
   localparam int STEP_W = $clog2(DIV_W + 1);

   // request function codes
   localparam logic FUNC_CLAIM   = 1'b0;
   localparam logic FUNC_RECEIVE = 1'b1;

   // register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PAGE_SIZE   = 2'd0,
      CSR_WINDOW_SIZE = 2'd1,
      CSR_TOTAL_PAGES = 2'd2,
      CSR_TOTAL_SIZE  = 2'd3
   } csr_index_type;

   // result kinds
   typedef enum logic [1:0] {
      KIND_CLAIM   = 2'd0,
      KIND_RECEIVE = 2'd1,
      KIND_RELEASE = 2'd2
   } kind_type;

   // operand select of the remainder unit
   typedef enum logic [1:0] {
      DIV_FRONT = 2'd0,
      DIV_PAGE  = 2'd1,
      DIV_LAST  = 2'd2
   } div_sel_type;

   // request word
   typedef struct packed {
      logic                  func;
      logic [PAGE_NUM_W-1:0] page_number;
      logic [PAGE_W-1:0]     data_size;
   } req_type;

   // response word
   typedef struct packed {
      kind_type              kind;
      logic                  accepted;
      logic [SLOT_W-1:0]     slot;
      logic [PAGE_NUM_W-1:0] released_page;
      logic [PAGE_W-1:0]     byte_count;
      logic                  last;
      logic                  done_res;
      logic [PAGE_NUM_W-1:0] window_first;
      logic [MAP_W-1:0]      received_map;
   } rsp_type;

   // controller commands
   typedef struct packed {
      logic        capture;
      logic        div_start;
      div_sel_type div_sel;
      logic        load_front;
      logic        load_slot;
      logic        load_last;
      logic        decide;
      logic        emit;
      logic        release_page;
   } ctrl_cmd_type;

   // datapath status
   typedef struct packed {
      logic div_done;
      logic fslot_valid;
      logic need_last;
      logic more;
      logic out_free;
   } dp_status_type;

endpackage
`default_nettype wire

// ===== rtl/core/page_reorder_window_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// page_reorder_window_top
// Sliding receive window over numbered pages: claims slots, takes received
// pages and releases them in order with their byte counts.
// ----------------------------------------------------------------------------
// The block takes one request word at a time. A claim goes from acceptance
// to its response word through capture, launch, the page-modulo-window
// remainder (one quotient bit per cycle in the shared remainder unit), the
// update and the response register. A receive takes the same path, then
// emits one word for every released page, each waiting for a free response
// register. After any register write the first request also recomputes the
// slot of the window front, and the first accepted receive derives the last
// page size from the total size. The next request is taken as soon as the
// previous response word is loaded, even while it waits.
// ----------------------------------------------------------------------------
module page_reorder_window_top import prw_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire req_type              req_data,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output rsp_type                   rsp_data,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [TSIZE_W-1:0]   csr_wdata
);

   ctrl_cmd_type  cmd;
   dp_status_type status;
   logic          csr_we;

   // register writes are always taken
   assign csr_ready = 1'b1;
   assign csr_we    = csr_valid && csr_ready;

   prw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   prw_datapath u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

`ifndef SYNTHESIS
   // one request in flight at a time
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while another is in progress");

   // a release is granted and moves the window just past its page
   a_release: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.kind == KIND_RELEASE) |->
         rsp_data.accepted && (rsp_data.window_first == rsp_data.released_page + 24'd1))
      else $error("release word inconsistent with window front");

   // a claim gives exactly one word
   a_claim_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.kind == KIND_CLAIM) |-> rsp_data.last)
      else $error("claim reply not marked last");
`endif

endmodule
`default_nettype wire

// ===== rtl/core/prw_rem_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// prw_rem_unit
// Restoring remainder unit: one dividend bit per cycle, msb first, for a
// selectable number of steps; pulses done with the remainder ready.
// ----------------------------------------------------------------------------
module prw_rem_unit import prw_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [DIV_W-1:0]  dividend,
   input  wire logic [PAGE_W-1:0] divisor,
   input  wire logic [STEP_W-1:0] steps,
   output logic                   done,
   output logic [PAGE_W-1:0]      rem
);

   logic              busy_ff;
   logic              done_ff;
   logic [STEP_W-1:0] cnt_ff;
   logic [DIV_W-1:0]  sh_ff;
   logic [PAGE_W-1:0] rem_ff;
   logic [PAGE_W-1:0] dvs_ff;
   logic [PAGE_W:0]   trial;
   logic [PAGE_W:0]   diff;
   logic [PAGE_W-1:0] rem_in;

   // one compare and subtract step
   always_comb begin
      trial  = {rem_ff, sh_ff[DIV_W-1]};
      diff   = trial - {1'b0, dvs_ff};
      rem_in = (trial >= {1'b0, dvs_ff}) ? diff[PAGE_W-1:0] : trial[PAGE_W-1:0];
   end

   // step counter and done pulse
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= steps;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - STEP_W'(1);
            if (cnt_ff == STEP_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // operand and partial remainder
   always_ff @(posedge clock) begin
      if (start) begin
         sh_ff  <= dividend;
         rem_ff <= '0;
         dvs_ff <= divisor;
      end else if (busy_ff) begin
         sh_ff  <= {sh_ff[DIV_W-2:0], 1'b0};
         rem_ff <= rem_in;
      end
   end

   assign done = done_ff;
   assign rem  = rem_ff;

endmodule
`default_nettype wire

// ===== rtl/core/prw_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// prw_datapath
// Registers, slot flags, window front and response register of the page
// reorder window, with the remainder unit for slot and last page size.
// ----------------------------------------------------------------------------
module prw_datapath import prw_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire req_type              req_data,
   input  wire ctrl_cmd_type         cmd,
   output dp_status_type             status,
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [TSIZE_W-1:0]   csr_wdata,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output rsp_type                   rsp_data
);

   // configuration registers
   logic [PAGE_W-1:0]     page_size_ff;
   logic [WIN_W-1:0]      window_size_ff;
   logic [PAGE_NUM_W-1:0] total_pages_ff;
   logic [TSIZE_W-1:0]    total_size_ff;

   // window state
   logic [PAGE_NUM_W-1:0] fpp_ff;
   logic [SLOT_W-1:0]     fslot_ff;
   logic                  fslot_valid_ff;
   logic [MAX_WINDOW-1:0] rcv_ff;
   logic [MAX_WINDOW-1:0] rcving_ff;
   logic [PAGE_W-1:0]     lastsz_ff;
   logic                  lp_valid_ff;
   logic [PAGE_NUM_W-1:0] stop_ff;
   logic                  walk_ff;

   // current item and pending result
   req_type               req_ff;
   logic [SLOT_W-1:0]     slot_ff;
   kind_type              rkind_ff;
   logic                  racc_ff;
   logic [SLOT_W-1:0]     rslot_ff;
   logic [PAGE_NUM_W-1:0] rpage_ff;
   logic [PAGE_W-1:0]     rbytes_ff;
   logic                  rsp_valid_ff;
   rsp_type               rsp_data_ff;

   logic [WIN_W-1:0]      w_eff;
   logic [PAGE_W-1:0]     psz;
   logic [PAGE_NUM_W:0]   win_end;
   logic [PAGE_NUM_W:0]   page_ext;
   logic [PAGE_NUM_W:0]   tp_ext;
   logic                  in_win;
   logic                  rx_ok;
   logic                  claim_ok;
   logic [PAGE_NUM_W-1:0] stop_in;
   logic                  avail;
   logic                  more;
   logic [WIN_W-1:0]      fslot_inc;
   logic [SLOT_W-1:0]     nslot;
   logic [PAGE_W-1:0]     rel_bytes;
   logic [WIN_W-1:0]      lane_sum [MAP_W];
   logic [WIN_W-1:0]      lane_idx [MAP_W];
   logic [MAP_W-1:0]      map;
   logic [DIV_W-1:0]      dividend;
   logic [PAGE_W-1:0]     divisor;
   logic [STEP_W-1:0]     steps;
   logic                  div_done;
   logic [PAGE_W-1:0]     div_rem;

   // effective window and page size
   always_comb begin
      if (window_size_ff == '0) begin
         w_eff = WIN_W'(1);
      end else if (window_size_ff > WIN_W'(MAX_WINDOW)) begin
         w_eff = WIN_W'(MAX_WINDOW);
      end else begin
         w_eff = window_size_ff;
      end
      if (page_size_ff == '0) begin
         psz = PAGE_W'(1);
      end else if (page_size_ff > PAGE_W'(MAX_PAGE_BYTES)) begin
         psz = PAGE_W'(MAX_PAGE_BYTES);
      end else begin
         psz = page_size_ff;
      end
   end

   // request checks
   always_comb begin
      win_end  = {1'b0, fpp_ff} + {{(PAGE_NUM_W + 1 - WIN_W){1'b0}}, w_eff};
      page_ext = {1'b0, req_ff.page_number};
      tp_ext   = {1'b0, total_pages_ff};
      in_win   = (req_ff.page_number >= fpp_ff) && (page_ext < win_end);
      rx_ok    = (req_ff.page_number < total_pages_ff) &&
                 !(((page_ext + 1'b1) < tp_ext) && (req_ff.data_size != psz)) &&
                 in_win;
      claim_ok = in_win && !rcv_ff[slot_ff] && !rcving_ff[slot_ff];
      stop_in  = (win_end < tp_ext) ? win_end[PAGE_NUM_W-1:0] : total_pages_ff;
   end

   // front of window release test
   always_comb begin
      avail     = (fpp_ff < stop_ff) && rcv_ff[fslot_ff];
      more      = walk_ff && avail;
      fslot_inc = {1'b0, fslot_ff} + WIN_W'(1);
      nslot     = (fslot_inc == w_eff) ? '0 : fslot_inc[SLOT_W-1:0];
      rel_bytes = ((fpp_ff == (total_pages_ff - PAGE_NUM_W'(1))) && (lastsz_ff != '0)) ?
                  lastsz_ff : psz;
   end

   // received bitmap, one lane per window offset
   always_comb begin
      for (int i = 0; i < MAP_W; i++) begin
         lane_sum[i] = {1'b0, fslot_ff} + WIN_W'(i);
         lane_idx[i] = (lane_sum[i] >= w_eff) ? (lane_sum[i] - w_eff) : lane_sum[i];
         map[i]      = (WIN_W'(i) < w_eff) && rcv_ff[lane_idx[i][SLOT_W-1:0]];
      end
   end

   // remainder operand select
   always_comb begin
      case (cmd.div_sel)
         DIV_FRONT: begin
            dividend = {fpp_ff, {(DIV_W - PAGE_NUM_W){1'b0}}};
            divisor  = {{(PAGE_W - WIN_W){1'b0}}, w_eff};
            steps    = STEP_W'(PAGE_NUM_W);
         end
         DIV_PAGE: begin
            dividend = {req_ff.page_number, {(DIV_W - PAGE_NUM_W){1'b0}}};
            divisor  = {{(PAGE_W - WIN_W){1'b0}}, w_eff};
            steps    = STEP_W'(PAGE_NUM_W);
         end
         default: begin
            dividend = total_size_ff;
            divisor  = psz;
            steps    = STEP_W'(DIV_W);
         end
      endcase
   end

   prw_rem_unit u_rem (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (dividend),
      .divisor  (divisor),
      .steps    (steps),
      .done     (div_done),
      .rem      (div_rem)
   );

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         page_size_ff   <= PAGE_W'(MAX_PAGE_BYTES);
         window_size_ff <= WIN_W'(MAX_WINDOW);
         total_pages_ff <= PAGE_NUM_W'(1);
         total_size_ff  <= '0;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_PAGE_SIZE:   page_size_ff   <= csr_wdata[PAGE_W-1:0];
            CSR_WINDOW_SIZE: window_size_ff <= csr_wdata[WIN_W-1:0];
            CSR_TOTAL_PAGES: total_pages_ff <= csr_wdata[PAGE_NUM_W-1:0];
            CSR_TOTAL_SIZE:  total_size_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // window state and slot flags
   always_ff @(posedge clock) begin
      if (reset) begin
         fpp_ff         <= '0;
         fslot_valid_ff <= 1'b0;
         rcv_ff         <= '0;
         rcving_ff      <= '0;
         lp_valid_ff    <= 1'b0;
         walk_ff        <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_we) begin
            fslot_valid_ff <= 1'b0;
            lp_valid_ff    <= 1'b0;
         end
         if (cmd.load_front) begin
            fslot_valid_ff <= 1'b1;
         end
         if (cmd.load_last) begin
            lp_valid_ff <= 1'b1;
         end
         if (cmd.decide) begin
            if (req_ff.func == FUNC_CLAIM) begin
               walk_ff <= 1'b0;
               if (claim_ok) begin
                  rcving_ff[slot_ff] <= 1'b1;
               end
            end else begin
               walk_ff <= rx_ok;
               if (rx_ok) begin
                  rcv_ff[slot_ff]    <= 1'b1;
                  rcving_ff[slot_ff] <= 1'b0;
               end
            end
         end
         if (cmd.release_page) begin
            rcv_ff[fslot_ff]    <= 1'b0;
            rcving_ff[fslot_ff] <= 1'b0;
            fpp_ff              <= fpp_ff + PAGE_NUM_W'(1);
         end
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // item, slot and pending result payload
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req_data;
      end
      if (cmd.load_front) begin
         fslot_ff <= div_rem[SLOT_W-1:0];
      end else if (cmd.release_page) begin
         fslot_ff <= nslot;
      end
      if (cmd.load_slot) begin
         slot_ff <= div_rem[SLOT_W-1:0];
      end
      if (cmd.load_last) begin
         lastsz_ff <= div_rem;
      end
      if (cmd.decide) begin
         rkind_ff  <= (req_ff.func == FUNC_CLAIM) ? KIND_CLAIM : KIND_RECEIVE;
         racc_ff   <= (req_ff.func == FUNC_CLAIM) ? claim_ok : rx_ok;
         rslot_ff  <= slot_ff;
         rpage_ff  <= '0;
         rbytes_ff <= '0;
         stop_ff   <= stop_in;
      end else if (cmd.release_page) begin
         rkind_ff  <= KIND_RELEASE;
         racc_ff   <= 1'b1;
         rslot_ff  <= fslot_ff;
         rpage_ff  <= fpp_ff;
         rbytes_ff <= rel_bytes;
      end
      if (cmd.emit) begin
         rsp_data_ff.kind          <= rkind_ff;
         rsp_data_ff.accepted      <= racc_ff;
         rsp_data_ff.slot          <= rslot_ff;
         rsp_data_ff.released_page <= rpage_ff;
         rsp_data_ff.byte_count    <= rbytes_ff;
         rsp_data_ff.last          <= !more;
         rsp_data_ff.done_res      <= (fpp_ff >= total_pages_ff);
         rsp_data_ff.window_first  <= fpp_ff;
         rsp_data_ff.received_map  <= map;
      end
   end

   // status to the controller
   always_comb begin
      status.div_done    = div_done;
      status.fslot_valid = fslot_valid_ff;
      status.need_last   = (req_ff.func == FUNC_RECEIVE) && rx_ok && !lp_valid_ff;
      status.more        = more;
      status.out_free    = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
`default_nettype wire

// ===== rtl/core/prw_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// prw_ctrl
// Sequencer of the page reorder window: takes one word, runs the slot and
// size remainders, applies the request and walks the releases.
// ----------------------------------------------------------------------------
module prw_ctrl import prw_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_ready,
   input  wire dp_status_type status,
   output ctrl_cmd_type       cmd
);

   typedef enum logic [7:0] {
      ST_IDLE   = 8'b0000_0001,
      ST_LAUNCH = 8'b0000_0010,
      ST_FMOD   = 8'b0000_0100,
      ST_PMOD   = 8'b0000_1000,
      ST_DECIDE = 8'b0001_0000,
      ST_LMOD   = 8'b0010_0000,
      ST_EMIT   = 8'b0100_0000,
      ST_REL    = 8'b1000_0000
   } state_type;

   state_type state_ff;
   state_type state_in;

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
            if (req_valid) begin
               state_in = ST_LAUNCH;
            end
         end
         ST_LAUNCH: begin
            cmd.div_start = 1'b1;
            if (status.fslot_valid) begin
               cmd.div_sel = DIV_PAGE;
               state_in    = ST_PMOD;
            end else begin
               cmd.div_sel = DIV_FRONT;
               state_in    = ST_FMOD;
            end
         end
         ST_FMOD: begin
            if (status.div_done) begin
               cmd.load_front = 1'b1;
               cmd.div_start  = 1'b1;
               cmd.div_sel    = DIV_PAGE;
               state_in       = ST_PMOD;
            end
         end
         ST_PMOD: begin
            cmd.div_sel = DIV_PAGE;
            if (status.div_done) begin
               cmd.load_slot = 1'b1;
               state_in      = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            cmd.decide = 1'b1;
            if (status.need_last) begin
               cmd.div_start = 1'b1;
               cmd.div_sel   = DIV_LAST;
               state_in      = ST_LMOD;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_LMOD: begin
            cmd.div_sel = DIV_LAST;
            if (status.div_done) begin
               cmd.load_last = 1'b1;
               state_in      = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = status.more ? ST_REL : ST_IDLE;
            end
         end
         ST_REL: begin
            cmd.release_page = 1'b1;
            state_in         = ST_EMIT;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire
